### src/rcv_pkg.sv
// ----------------------------------------------------------------------------
// rcv_pkg
// Types and constants shared by the container validator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rcv_pkg;

  // request and result payloads
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } rcv_in_t;

  typedef struct packed {
    logic        valid_res;
    logic [31:0] rom_length;
    logic [23:0] resource_total;
    logic [2:0]  error_code;
  } rcv_out_t;

  // parse phases
  localparam logic [2:0] PH_SIG  = 3'd0;
  localparam logic [2:0] PH_LEAD = 3'd1;
  localparam logic [2:0] PH_DLO  = 3'd2;
  localparam logic [2:0] PH_LMID = 3'd3;
  localparam logic [2:0] PH_LLO  = 3'd4;
  localparam logic [2:0] PH_SKIP = 3'd5;

  // verdict codes
  localparam logic [2:0] ERR_OK    = 3'd0;
  localparam logic [2:0] ERR_SIG   = 3'd1;
  localparam logic [2:0] ERR_TYPE  = 3'd2;
  localparam logic [2:0] ERR_ID    = 3'd3;
  localparam logic [2:0] ERR_TRUNC = 3'd4;
  localparam logic [2:0] ERR_META  = 3'd5;

  // lead byte kinds, top two bits
  localparam logic [1:0] LEAD_TYPE  = 2'b00;
  localparam logic [1:0] LEAD_DELTA = 2'b01;
  localparam logic [1:0] LEAD_SHORT = 2'b10;
  localparam logic [1:0] LEAD_LONG  = 2'b11;

  localparam logic [6:0]  TYPE_ID_MAX   = 7'h3f;
  localparam logic [22:0] LONG_LEN_BIAS = 23'd65;

  localparam logic [7:0] SIG_BYTES [8] = '{
    8'h00, 8'hff, 8'h50, 8'h42, 8'h4c, 8'h52, 8'h4f, 8'h4d
  };

  typedef struct packed {
    logic [2:0]  phase;
    logic [3:0]  sig_index;
    logic [6:0]  type_id;
    logic [16:0] resource_id;
    logic [22:0] skip_remaining;
    logic [13:0] pending_high;
    logic [31:0] byte_total;
    logic [23:0] resource_count;
    logic        metadata_seen;
    logic        verdict_given;
  } rcv_state_t;

  localparam rcv_state_t STATE_CLEAR = '{
    phase:          PH_SIG,
    sig_index:      4'd0,
    type_id:        7'd1,
    resource_id:    17'd1,
    skip_remaining: 23'd0,
    pending_high:   14'd0,
    byte_total:     32'd0,
    resource_count: 24'd0,
    metadata_seen:  1'b0,
    verdict_given:  1'b0
  };

endpackage

`default_nettype wire

### src/rcv_step.sv
// ----------------------------------------------------------------------------
// rcv_step
// Next-state and verdict logic for one byte of the container stream.
// ----------------------------------------------------------------------------
`default_nettype none

module rcv_step import rcv_pkg::*; (
  input  rcv_state_t state,
  input  rcv_in_t    req,
  input  logic [5:0] meta_type,
  output rcv_state_t state_nxt,
  output logic       emit,
  output rcv_out_t   result
);

  logic [7:0]  b;
  logic [5:0]  low6;
  logic [2:0]  code;
  logic        done;
  rcv_state_t  nxt;

  assign b    = req.data_byte;
  assign low6 = req.data_byte[5:0];

  always_comb begin
    nxt  = state;
    code = ERR_OK;
    done = 1'b0;
    if (state.verdict_given) begin
      // drop bytes until the end of the stream
      if (req.last) begin
        nxt = STATE_CLEAR;
      end
    end else begin
      if (state.byte_total != '1) begin
        nxt.byte_total = state.byte_total + 32'd1;
      end
      unique case (state.phase)
        PH_SIG: begin
          if (b != SIG_BYTES[state.sig_index[2:0]]) begin
            code = ERR_SIG;
            done = 1'b1;
          end else if (state.sig_index[2:0] == 3'd7) begin
            nxt.sig_index = 4'd0;
            nxt.phase     = PH_LEAD;
          end else begin
            nxt.sig_index = state.sig_index + 4'd1;
          end
        end
        PH_LEAD: begin
          if (b == 8'd0) begin
            code = state.metadata_seen ? ERR_OK : ERR_META;
            done = 1'b1;
          end else begin
            case (b[7:6])
              LEAD_TYPE: begin
                nxt.type_id     = state.type_id + {1'b0, low6};
                nxt.resource_id = 17'd1;
                if (nxt.type_id > TYPE_ID_MAX) begin
                  code = ERR_TYPE;
                  done = 1'b1;
                end
              end
              LEAD_DELTA: begin
                if (state.resource_id[16]) begin
                  code = ERR_ID;
                  done = 1'b1;
                end else begin
                  nxt.pending_high = {8'd0, low6};
                  nxt.phase        = PH_DLO;
                end
              end
              default: begin
                // short or long resource lead: the resource counts here
                if (state.resource_id[16]) begin
                  code = ERR_ID;
                  done = 1'b1;
                end else begin
                  if (state.resource_count != '1) begin
                    nxt.resource_count = state.resource_count + 24'd1;
                  end
                  if (state.type_id == {1'b0, meta_type} && state.resource_id == 17'd1) begin
                    nxt.metadata_seen = 1'b1;
                  end
                  nxt.resource_id = state.resource_id + 17'd1;
                  if (b[7:6] == LEAD_SHORT) begin
                    nxt.skip_remaining = {17'd0, low6} + 23'd1;
                    nxt.phase          = PH_SKIP;
                  end else begin
                    nxt.pending_high = {8'd0, low6};
                    nxt.phase        = PH_LMID;
                  end
                end
              end
            endcase
          end
        end
        PH_DLO: begin
          nxt.resource_id  = state.resource_id + {3'd0, state.pending_high[5:0], b};
          nxt.pending_high = 14'd0;
          nxt.phase        = PH_LEAD;
          if (nxt.resource_id[16]) begin
            code = ERR_ID;
            done = 1'b1;
          end
        end
        PH_LMID: begin
          nxt.pending_high = {state.pending_high[5:0], b};
          nxt.phase        = PH_LLO;
        end
        PH_LLO: begin
          nxt.skip_remaining = {1'b0, state.pending_high, b} + LONG_LEN_BIAS;
          nxt.pending_high   = 14'd0;
          nxt.phase          = PH_SKIP;
        end
        default: begin
          if (state.skip_remaining != 23'd0) begin
            nxt.skip_remaining = state.skip_remaining - 23'd1;
          end
          if (nxt.skip_remaining == 23'd0) begin
            nxt.phase = PH_LEAD;
          end
        end
      endcase
      if (!done && req.last) begin
        done = 1'b1;
        if (nxt.phase == PH_LEAD) begin
          code = nxt.metadata_seen ? ERR_OK : ERR_META;
        end else if (nxt.phase == PH_SIG) begin
          code = ERR_SIG;
        end else begin
          code = ERR_TRUNC;
        end
      end
    end

    result.valid_res      = (code == ERR_OK);
    result.rom_length     = nxt.byte_total;
    result.resource_total = nxt.resource_count;
    result.error_code     = code;

    if (done) begin
      nxt.verdict_given = 1'b1;
      if (req.last) begin
        nxt = STATE_CLEAR;
      end
    end
  end

  assign state_nxt = nxt;
  assign emit      = done;

endmodule

`default_nettype wire

### src/rcv_out_stage.sv
// ----------------------------------------------------------------------------
// rcv_out_stage
// Result register with valid/ready handshake; frees itself when taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rcv_out_stage import rcv_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     load,
  input  rcv_out_t load_data,
  output logic     space,
  output logic     out_valid,
  input  logic     out_ready,
  output rcv_out_t out_data
);

  logic     valid_r;
  logic     valid_nxt;
  rcv_out_t data_r;

  // room when empty or when the held result leaves this cycle
  assign space     = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

### src/rom_container_validator_top.sv
// ----------------------------------------------------------------------------
// rom_container_validator_top
// Checks a byte stream for a signed resource container and reports one
// verdict per image: length, resource count and error code.
// ----------------------------------------------------------------------------
//  channel | ports                         | payload
//  --------+-------------------------------+-----------------------------------
//  in      | in_valid, in_ready, in_data   | rcv_in_t: data_byte, last
//  out     | out_valid, out_ready, out_data| rcv_out_t: valid_res, rom_length,
//          |                               |   resource_total, error_code
//  cfg     | cfg_valid, cfg_ready, cfg_data| metadata type id, 6 bits
//
//  one byte per cycle while in_ready is high; a verdict appears on out in the cycle after its byte
//  the parse state is registered straight from each taken byte, so bytes go back to back
//  in_ready drops only while a verdict is held and out_ready is low
//  synchronous reset clears stream state and sets the metadata type id to 1
//  cfg_ready is always high
// ----------------------------------------------------------------------------
`default_nettype none

module rom_container_validator_top import rcv_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  rcv_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output rcv_out_t   out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [5:0] cfg_data
);

  rcv_state_t state_r;
  rcv_state_t state_nxt;
  logic [5:0] meta_type_r;
  logic       in_accept;
  logic       emit;
  logic       space;
  rcv_out_t   result;

  assign cfg_ready = 1'b1;
  assign in_ready  = space;
  assign in_accept = in_valid && space;

  rcv_step u_step (
    .state     (state_r),
    .req       (in_data),
    .meta_type (meta_type_r),
    .state_nxt (state_nxt),
    .emit      (emit),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_CLEAR;
      meta_type_r <= 6'd1;
    end else begin
      if (in_accept) begin
        state_r <= state_nxt;
      end
      if (cfg_valid) begin
        meta_type_r <= cfg_data;
      end
    end
  end

  rcv_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_accept && emit),
    .load_data (result),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

### src/rcv_checker.sv
// ----------------------------------------------------------------------------
// rcv_checker
// Port-level checks for the container validator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rcv_checker import rcv_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input rcv_in_t    in_data,
  input logic       out_valid,
  input logic       out_ready,
  input rcv_out_t   out_data,
  input logic       cfg_valid,
  input logic       cfg_ready,
  input logic [5:0] cfg_data
);

  // a held verdict stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no request taken while a verdict waits with nowhere to go
  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request accepted over a stalled result");

  // empty result stage always takes a request
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty result stage");

  // a fresh verdict follows an accepted byte and counts at least that byte
  a_verdict_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready) && out_data.rom_length != 32'd0 &&
      (out_data.error_code == ERR_OK || out_data.error_code == ERR_SIG ||
       out_data.error_code == ERR_TYPE || out_data.error_code == ERR_ID ||
       out_data.error_code == ERR_TRUNC || out_data.error_code == ERR_META) &&
      (out_data.valid_res == (out_data.error_code == ERR_OK)))
    else $error("verdict without a source byte or with a bad code");

endmodule

bind rom_container_validator_top rcv_checker u_rcv_checker (.*);

`default_nettype wire
